// ===== rtl/sabc_pkg.sv =====
// Shared constants, types and helpers for the summed-area box counter.
package sabc_pkg;

  localparam int MAX_ROWS   = 256;
  localparam int MAX_COLS   = 256;
  localparam int NUM_IMAGES = 4;

  localparam int DEPTH  = NUM_IMAGES * MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int RSZ_W  = $clog2(MAX_ROWS + 1);
  localparam int CSZ_W  = $clog2(MAX_COLS + 1);

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int IMGS_W    = 3;
  localparam int IMG_W     = 2;
  localparam int CRD_W     = 12;
  localparam int TBL_W     = 17;
  localparam int RC_W      = 9;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMGS = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L_RD,
    ST_L_WR,
    ST_Q_PREP,
    ST_Q_REJ,
    ST_Q_A0,
    ST_Q_A1,
    ST_Q_A2,
    ST_Q_A3,
    ST_Q_ACC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       accept;
    logic       q_prep;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       acc_en;
    logic [1:0] acc_sel;
    logic       ld_rd;
    logic       ld_wr;
    logic       emit;
    logic       emit_rej;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    logic ld_ok;
    logic q_reject;
  } sts_t;

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [IMG_W-1:0] img,
                                                 input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    return ADDR_W'((32'(img) * MAX_ROWS + 32'(row)) * MAX_COLS + 32'(col));
  endfunction

endpackage

// ===== rtl/summed_area_box_count.sv =====
// Top level: summed-area table builder and box-count query engine.
// Load item: read the entry above, then write the new sum, then return to idle.
// Query item: prep, four table reads, accumulate; the result strobe is registered;
// a rejected query skips the reads. Four serial reads on one table port.
// Synchronous active-low reset clears control state and config to full size;
// the table itself is not cleared. Results cannot be stalled by the receiver.
module summed_area_box_count (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic [sabc_pkg::IMG_W-1:0]         in_image_index,
  input  logic                               in_first_pixel,
  input  logic                               in_pixel_bit,
  input  logic signed [sabc_pkg::CRD_W-1:0]  in_low_row,
  input  logic signed [sabc_pkg::CRD_W-1:0]  in_low_col,
  input  logic signed [sabc_pkg::CRD_W-1:0]  in_high_row,
  input  logic signed [sabc_pkg::CRD_W-1:0]  in_high_col,
  output logic                               out_strobe,
  output logic [sabc_pkg::TBL_W-1:0]         out_box_count,
  output logic                               out_rejected,
  input  logic                               cfg_we,
  input  logic [sabc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sabc_pkg::CFG_W-1:0]         cfg_data
);
  import sabc_pkg::*;

  ctl_t ctl;
  sts_t sts;

  sabc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  sabc_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (in_command),
    .in_image_index (in_image_index),
    .in_first_pixel (in_first_pixel),
    .in_pixel_bit   (in_pixel_bit),
    .in_low_row     (in_low_row),
    .in_low_col     (in_low_col),
    .in_high_row    (in_high_row),
    .in_high_col    (in_high_col),
    .out_strobe     (out_strobe),
    .out_box_count  (out_box_count),
    .out_rejected   (out_rejected)
  );

endmodule

// ===== rtl/sabc_dpath.sv =====
// Datapath: config registers, load counters, area table memory, query accumulator.
module sabc_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sabc_pkg::ctl_t                     ctl,
  output sabc_pkg::sts_t                     sts,
  input  logic                               cfg_we,
  input  logic [sabc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sabc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_command,
  input  logic [sabc_pkg::IMG_W-1:0]         in_image_index,
  input  logic                               in_first_pixel,
  input  logic                               in_pixel_bit,
  input  logic signed [sabc_pkg::CRD_W-1:0]  in_low_row,
  input  logic signed [sabc_pkg::CRD_W-1:0]  in_low_col,
  input  logic signed [sabc_pkg::CRD_W-1:0]  in_high_row,
  input  logic signed [sabc_pkg::CRD_W-1:0]  in_high_col,
  output logic                               out_strobe,
  output logic [sabc_pkg::TBL_W-1:0]         out_box_count,
  output logic                               out_rejected
);
  import sabc_pkg::*;

  logic [CFG_W-1:0]        cfg_rows_r, cfg_cols_r;
  logic [IMGS_W-1:0]       cfg_imgs_r;
  logic [RSZ_W-1:0]        eff_rows;
  logic [CSZ_W-1:0]        eff_cols;

  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [RC_W-1:0]         rc_r, rc_nxt;

  logic [IMG_W-1:0]        img_r;
  logic signed [CRD_W-1:0] lr_r, lc_r, hr_r, hc_r;
  logic [ROW_W-1:0]        r0_r, r1_r, r0_m1;
  logic [COL_W-1:0]        c0_r, c1_r, c0_m1;
  logic                    r0_pos_r, c0_pos_r;

  logic [TBL_W-1:0]        tbl_mem [DEPTH];
  logic [TBL_W-1:0]        rd_data_r, above, wr_data;
  logic [ADDR_W-1:0]       mem_addr;
  logic [TBL_W-1:0]        acc_r, acc_sum;

  logic                    out_strobe_r, out_rejected_r;
  logic [TBL_W-1:0]        out_box_count_r;

  function automatic logic [31:0] clamp_crd(input logic signed [CRD_W-1:0] v,
                                            input logic [31:0] sz);
    logic [31:0] vu;
    vu = 32'(v);
    if (v < 0) return 32'd0;
    if (vu >= sz) return sz - 32'd1;
    return vu;
  endfunction

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= CFG_W'(256);
      cfg_cols_r <= CFG_W'(256);
      cfg_imgs_r <= IMGS_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: cfg_rows_r <= cfg_data;
        CFG_COLS: cfg_cols_r <= cfg_data;
        CFG_IMGS: cfg_imgs_r <= cfg_data[IMGS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_rows_r == '0) eff_rows = RSZ_W'(1);
    else if (32'(cfg_rows_r) > MAX_ROWS) eff_rows = RSZ_W'(MAX_ROWS);
    else eff_rows = RSZ_W'(cfg_rows_r);
    if (cfg_cols_r == '0) eff_cols = CSZ_W'(1);
    else if (32'(cfg_cols_r) > MAX_COLS) eff_cols = CSZ_W'(MAX_COLS);
    else eff_cols = CSZ_W'(cfg_cols_r);
  end

  // status
  assign sts.is_query = (in_command == CMD_QUERY);
  assign sts.ld_ok    = (32'(in_image_index) < NUM_IMAGES);
  assign sts.q_reject = (32'(img_r) >= 32'(cfg_imgs_r)) || (32'(img_r) >= NUM_IMAGES) ||
                        (lr_r > hr_r) || (lc_r > hc_r);

  // load counters
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    rc_nxt  = rc_r;
    if (ctl.accept && !sts.is_query && sts.ld_ok) begin
      if (in_first_pixel) begin
        row_nxt = '0;
        col_nxt = '0;
        rc_nxt  = RC_W'(in_pixel_bit);
      end else begin
        rc_nxt = rc_r + RC_W'(in_pixel_bit);
      end
    end
    if (ctl.ld_wr) begin
      if (32'(col_r) + 32'd1 >= 32'(eff_cols)) begin
        col_nxt = '0;
        rc_nxt  = '0;
        if (32'(row_r) + 32'd1 >= 32'(eff_rows)) row_nxt = '0;
        else row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      rc_r  <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      rc_r  <= rc_nxt;
    end
  end

  // item capture and corner clamping
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      img_r <= in_image_index;
      lr_r  <= in_low_row;
      lc_r  <= in_low_col;
      hr_r  <= in_high_row;
      hc_r  <= in_high_col;
    end
    if (ctl.q_prep) begin
      r0_r     <= ROW_W'(clamp_crd(lr_r, 32'(eff_rows)));
      r1_r     <= ROW_W'(clamp_crd(hr_r, 32'(eff_rows)));
      c0_r     <= COL_W'(clamp_crd(lc_r, 32'(eff_cols)));
      c1_r     <= COL_W'(clamp_crd(hc_r, 32'(eff_cols)));
      r0_pos_r <= (clamp_crd(lr_r, 32'(eff_rows)) != 32'd0);
      c0_pos_r <= (clamp_crd(lc_r, 32'(eff_cols)) != 32'd0);
    end
  end

  assign r0_m1 = r0_r - ROW_W'(1);
  assign c0_m1 = c0_r - COL_W'(1);

  // single memory port
  always_comb begin
    mem_addr = tbl_addr(img_r, r1_r, c1_r);
    if (ctl.ld_wr) begin
      mem_addr = tbl_addr(img_r, row_r, col_r);
    end else if (ctl.ld_rd) begin
      mem_addr = tbl_addr(img_r, row_r - ROW_W'(1), col_r);
    end else begin
      case (ctl.rd_sel)
        2'd0:    mem_addr = tbl_addr(img_r, r1_r, c1_r);
        2'd1:    mem_addr = tbl_addr(img_r, r0_m1, c1_r);
        2'd2:    mem_addr = tbl_addr(img_r, r1_r, c0_m1);
        2'd3:    mem_addr = tbl_addr(img_r, r0_m1, c0_m1);
        default: mem_addr = tbl_addr(img_r, r1_r, c1_r);
      endcase
    end
  end

  assign above   = (row_r == '0) ? '0 : rd_data_r;
  assign wr_data = above + TBL_W'(rc_r);

  always_ff @(posedge clk) begin
    if (ctl.ld_wr) begin
      tbl_mem[mem_addr] <= wr_data;
    end
    if (ctl.ld_rd || ctl.rd_en) begin
      rd_data_r <= tbl_mem[mem_addr];
    end
  end

  // four-term accumulate
  always_comb begin
    case (ctl.acc_sel)
      2'd0:    acc_sum = rd_data_r;
      2'd1:    acc_sum = r0_pos_r ? acc_r - rd_data_r : acc_r;
      2'd2:    acc_sum = c0_pos_r ? acc_r - rd_data_r : acc_r;
      2'd3:    acc_sum = (r0_pos_r && c0_pos_r) ? acc_r + rd_data_r : acc_r;
      default: acc_sum = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      acc_r <= acc_sum;
    end
    if (ctl.emit) begin
      out_box_count_r <= acc_sum;
      out_rejected_r  <= 1'b0;
    end else if (ctl.emit_rej) begin
      out_box_count_r <= '0;
      out_rejected_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctl.emit || ctl.emit_rej;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_box_count = out_box_count_r;
  assign out_rejected  = out_rejected_r;

endmodule

// ===== rtl/sabc_ctrl.sv =====
// Controller state machine sequencing loads and four-read queries.
module sabc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  sabc_pkg::sts_t sts,
  output sabc_pkg::ctl_t ctl
);
  import sabc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (sts.is_query) state_nxt = ST_Q_PREP;
          else if (sts.ld_ok) state_nxt = ST_L_RD;
        end
      end
      ST_L_RD:   state_nxt = ST_L_WR;
      ST_L_WR:   state_nxt = ST_IDLE;
      ST_Q_PREP: state_nxt = sts.q_reject ? ST_Q_REJ : ST_Q_A0;
      ST_Q_REJ:  state_nxt = ST_IDLE;
      ST_Q_A0:   state_nxt = ST_Q_A1;
      ST_Q_A1:   state_nxt = ST_Q_A2;
      ST_Q_A2:   state_nxt = ST_Q_A3;
      ST_Q_A3:   state_nxt = ST_Q_ACC;
      ST_Q_ACC:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
      end
      ST_L_RD:   ctl.ld_rd = 1'b1;
      ST_L_WR:   ctl.ld_wr = 1'b1;
      ST_Q_PREP: ctl.q_prep = 1'b1;
      ST_Q_REJ:  ctl.emit_rej = 1'b1;
      ST_Q_A0: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = 2'd0;
      end
      ST_Q_A1: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_sel  = 2'd1;
        ctl.acc_en  = 1'b1;
        ctl.acc_sel = 2'd0;
      end
      ST_Q_A2: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_sel  = 2'd2;
        ctl.acc_en  = 1'b1;
        ctl.acc_sel = 2'd1;
      end
      ST_Q_A3: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_sel  = 2'd3;
        ctl.acc_en  = 1'b1;
        ctl.acc_sel = 2'd2;
      end
      ST_Q_ACC: begin
        ctl.acc_en  = 1'b1;
        ctl.acc_sel = 2'd3;
        ctl.emit    = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

`ifndef SYNTHESIS
  a_acc_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Q_ACC) |-> ($past(state_r) == ST_Q_A3))
    else $error("accumulate step without full read sequence");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_L_WR) |-> ($past(state_r) == ST_L_RD))
    else $error("table write without preceding above read");

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.emit, ctl.emit_rej, ctl.ld_wr, ctl.accept}))
    else $error("conflicting datapath commands");

  a_reject_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Q_REJ) |-> ($past(state_r) == ST_Q_PREP))
    else $error("reject emitted outside query check");
`endif

endmodule
